### rtl/bbsp_pkg.sv
// Shared types, widths and codes for the spare buffer pool.
// Used by bbsp_slot_ram, bounded_buffer_spare_pool and the testbench; depends on nothing.
`default_nettype none

package bbsp_pkg;

  // Pool geometry
  localparam int unsigned SlotCount = 8;
  localparam int unsigned IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW      = $clog2(SlotCount + 1);

  // Field widths
  localparam int unsigned CapW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinRetain = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRetain = 1'd1;

  // Configuration reset values
  localparam logic [CapW-1:0] MinRetainRst = 32'd64;
  localparam logic [CapW-1:0] MaxRetainRst = 32'd65536;

  // One pool entry
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [CapW-1:0]    capacity;
  } slot_t;

  // Write request into the slot memory
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    slot_t           data;
  } slot_wr_t;

  // Result codes
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_STORED   = 3'd2,
    ST_REPLACED = 3'd3,
    ST_WINDOW   = 3'd4,
    ST_SMALL    = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_MIN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/bbsp_slot_ram.sv
// Slot memory of the spare pool: one write port, one read port, registered read.
// Depends on bbsp_pkg for the entry and write request types.
`default_nettype none

module bbsp_slot_ram (
  input  wire logic                           clk_i,
  input  wire bbsp_pkg::slot_wr_t             wr_i,
  input  wire logic [bbsp_pkg::IdxW-1:0]      rd_addr_i,
  output bbsp_pkg::slot_t                     rd_data_o
);

  bbsp_pkg::slot_t mem_q [bbsp_pkg::SlotCount];
  bbsp_pkg::slot_t rd_data_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/bounded_buffer_spare_pool.sv
// Spare buffer pool: top level with the request sequencer and output register.
// Depends on bbsp_pkg and bbsp_slot_ram.
`default_nettype none

// The pool holds up to SlotCount spare buffers (handle plus capacity) in a
// one-read-port slot memory, and the sequencer walks that memory one entry per
// cycle. A take scans the live entries newest first; on a hit it moves the last
// live entry into the hole it leaves, unless the hit is that entry, and then
// loads the result. A miss on an empty pool, and a give that is out of window
// or fits in free room, go straight to the result; a give into a full pool
// scans every slot for the smallest entry. One transaction is worked at a time;
// a finished result sits in the output register and the next transaction is
// accepted while it waits. Configuration writes are taken at any time and must
// only be issued while the pool is idle.
module bounded_buffer_spare_pool (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [bbsp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [bbsp_pkg::CapW-1:0]        cfg_data_i,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [bbsp_pkg::CapW-1:0]        size_value_i,
  input  wire logic [bbsp_pkg::HandleW-1:0]     buffer_handle_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [2:0]                            status_o,
  output logic [bbsp_pkg::HandleW-1:0]          out_handle_o,
  output logic [bbsp_pkg::CapW-1:0]             out_capacity_o
);

  localparam logic [bbsp_pkg::IdxW-1:0] LastSlot = bbsp_pkg::IdxW'(bbsp_pkg::SlotCount - 1);
  localparam logic [bbsp_pkg::CntW-1:0] FullCnt  = bbsp_pkg::CntW'(bbsp_pkg::SlotCount);

  // Control state
  bbsp_pkg::state_e                state_q, state_d;
  logic [bbsp_pkg::CntW-1:0]       live_q, live_d;
  logic                            pend_q, pend_d;
  logic                            out_valid_q, out_valid_d;
  logic [bbsp_pkg::CapW-1:0]       min_ret_q, max_ret_q;

  // Datapath registers
  logic [bbsp_pkg::IdxW-1:0]       scan_q, scan_d;
  logic [bbsp_pkg::IdxW-1:0]       cmp_q, cmp_d;
  logic [bbsp_pkg::IdxW-1:0]       pos_q, pos_d;
  logic [bbsp_pkg::CapW-1:0]       req_size_q, req_size_d;
  logic [bbsp_pkg::HandleW-1:0]    req_handle_q, req_handle_d;
  logic [bbsp_pkg::CapW-1:0]       min_cap_q, min_cap_d;
  logic [bbsp_pkg::HandleW-1:0]    min_handle_q, min_handle_d;
  bbsp_pkg::status_e               res_status_q, res_status_d;
  logic [bbsp_pkg::HandleW-1:0]    res_handle_q, res_handle_d;
  logic [bbsp_pkg::CapW-1:0]       res_cap_q, res_cap_d;
  bbsp_pkg::status_e               out_status_q, out_status_d;
  logic [bbsp_pkg::HandleW-1:0]    out_handle_q, out_handle_d;
  logic [bbsp_pkg::CapW-1:0]       out_cap_q, out_cap_d;

  // Memory interface
  bbsp_pkg::slot_wr_t              ram_wr;
  logic [bbsp_pkg::IdxW-1:0]       rd_addr;
  bbsp_pkg::slot_t                 rd_data;

  // Helpers
  logic                            in_fire;
  logic                            out_fire;
  logic                            out_load;
  logic                            in_window;
  logic [bbsp_pkg::CntW-1:0]       live_m1;
  logic [bbsp_pkg::IdxW-1:0]       last_idx;
  logic                            take_new;
  logic [bbsp_pkg::CapW-1:0]       best_cap;
  logic [bbsp_pkg::HandleW-1:0]    best_handle;
  logic [bbsp_pkg::IdxW-1:0]       best_pos;

  bbsp_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != bbsp_pkg::S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == bbsp_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_window  = (size_value_i >= min_ret_q) && (size_value_i <= max_ret_q);
  assign live_m1    = live_q - bbsp_pkg::CntW'(1);
  assign last_idx   = live_m1[bbsp_pkg::IdxW-1:0];

  // Fold the entry under compare into the running minimum (first index wins ties)
  always_comb begin
    take_new    = (cmp_q == '0) || (rd_data.capacity < min_cap_q);
    best_cap    = take_new ? rd_data.capacity : min_cap_q;
    best_handle = take_new ? rd_data.handle   : min_handle_q;
    best_pos    = take_new ? cmp_q            : pos_q;
  end

  // Sequence one transaction through the slot memory
  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    pend_d       = pend_q;
    scan_d       = scan_q;
    cmp_d        = cmp_q;
    pos_d        = pos_q;
    req_size_d   = req_size_q;
    req_handle_d = req_handle_q;
    min_cap_d    = min_cap_q;
    min_handle_d = min_handle_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_cap_d    = res_cap_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_cap_d    = out_cap_q;
    out_valid_d  = out_valid_q && !out_fire;
    ram_wr       = '0;
    rd_addr      = scan_q;

    case (state_q)
      bbsp_pkg::S_IDLE: begin
        if (in_fire) begin
          req_size_d   = size_value_i;
          req_handle_d = buffer_handle_i;
          pend_d       = 1'b0;
          res_handle_d = '0;
          res_cap_d    = '0;
          if (!req_type_i) begin
            if (live_q == '0) begin
              res_status_d = bbsp_pkg::ST_MISS;
              state_d      = bbsp_pkg::S_DONE;
            end else begin
              scan_d  = last_idx;
              state_d = bbsp_pkg::S_TAKE;
            end
          end else if (!in_window) begin
            res_status_d = bbsp_pkg::ST_WINDOW;
            state_d      = bbsp_pkg::S_DONE;
          end else if (live_q < FullCnt) begin
            // append into the first free slot
            ram_wr.en            = 1'b1;
            ram_wr.addr          = live_q[bbsp_pkg::IdxW-1:0];
            ram_wr.data.handle   = buffer_handle_i;
            ram_wr.data.capacity = size_value_i;
            live_d               = live_q + bbsp_pkg::CntW'(1);
            res_status_d         = bbsp_pkg::ST_STORED;
            state_d              = bbsp_pkg::S_DONE;
          end else begin
            scan_d  = '0;
            state_d = bbsp_pkg::S_MIN;
          end
        end
      end

      bbsp_pkg::S_TAKE: begin
        if (pend_q && (rd_data.capacity >= req_size_q)) begin
          // hit: hand out this entry and shrink the pool
          res_status_d = bbsp_pkg::ST_HIT;
          res_handle_d = rd_data.handle;
          res_cap_d    = rd_data.capacity;
          pos_d        = cmp_q;
          live_d       = live_m1;
          state_d      = (cmp_q == last_idx) ? bbsp_pkg::S_DONE : bbsp_pkg::S_MOVE_RD;
        end else if (pend_q && (cmp_q == '0)) begin
          res_status_d = bbsp_pkg::ST_MISS;
          state_d      = bbsp_pkg::S_DONE;
        end else begin
          // advance toward the oldest entry
          pend_d = 1'b1;
          cmp_d  = scan_q;
          if (scan_q != '0) begin
            scan_d = scan_q - bbsp_pkg::IdxW'(1);
          end
        end
      end

      bbsp_pkg::S_MOVE_RD: begin
        // live_q already counts one less, so it indexes the old last entry
        rd_addr = live_q[bbsp_pkg::IdxW-1:0];
        state_d = bbsp_pkg::S_MOVE_WR;
      end

      bbsp_pkg::S_MOVE_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = pos_q;
        ram_wr.data = rd_data;
        state_d     = bbsp_pkg::S_DONE;
      end

      bbsp_pkg::S_MIN: begin
        if (pend_q) begin
          min_cap_d    = best_cap;
          min_handle_d = best_handle;
          pos_d        = best_pos;
        end
        if (pend_q && (cmp_q == LastSlot)) begin
          if (req_size_q <= best_cap) begin
            res_status_d = bbsp_pkg::ST_SMALL;
          end else begin
            // evict the smallest entry
            ram_wr.en            = 1'b1;
            ram_wr.addr          = best_pos;
            ram_wr.data.handle   = req_handle_q;
            ram_wr.data.capacity = req_size_q;
            res_status_d         = bbsp_pkg::ST_REPLACED;
            res_handle_d         = best_handle;
            res_cap_d            = best_cap;
          end
          state_d = bbsp_pkg::S_DONE;
        end else begin
          pend_d = 1'b1;
          cmp_d  = scan_q;
          if (scan_q != LastSlot) begin
            scan_d = scan_q + bbsp_pkg::IdxW'(1);
          end
        end
      end

      bbsp_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_cap_d    = res_cap_q;
          state_d      = bbsp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bbsp_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbsp_pkg::S_IDLE;
      live_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ret_q <= bbsp_pkg::MinRetainRst;
      max_ret_q <= bbsp_pkg::MaxRetainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbsp_pkg::CfgMinRetain: min_ret_q <= cfg_data_i;
        bbsp_pkg::CfgMaxRetain: max_ret_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    cmp_q        <= cmp_d;
    pos_q        <= pos_d;
    req_size_q   <= req_size_d;
    req_handle_q <= req_handle_d;
    min_cap_q    <= min_cap_d;
    min_handle_q <= min_handle_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_cap_q    <= res_cap_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_cap_q    <= out_cap_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_handle_o   = out_handle_q;
  assign out_capacity_o = out_cap_q;

  // The live count never exceeds the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= FullCnt)
    else $error("live count above pool size");

  // An in-window give into a pool with room grows it by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_type_i && in_window && (live_q < FullCnt))
      |=> (live_q == $past(live_q) + bbsp_pkg::CntW'(1)))
    else $error("append did not grow the pool");

  // A hit hands out a buffer large enough for the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == bbsp_pkg::ST_HIT)) |-> (res_cap_q >= req_size_q))
    else $error("take hit returned an undersized buffer");

  // A replacement only evicts a strictly smaller buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == bbsp_pkg::ST_REPLACED)) |-> (res_cap_q < req_size_q))
    else $error("replacement evicted a buffer not smaller than the new one");

  // A finished result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### test/tb_bounded_buffer_spare_pool.sv
// Self-checking testbench for the spare buffer pool (bounded_buffer_spare_pool).
// Drives directed and random take/give transactions under random idling. Typed
// rows check against the table, others against a pool predictor. Uses bbsp_pkg.
`timescale 1ns / 1ps

module tb_bounded_buffer_spare_pool;
  import bbsp_pkg::*;

  localparam logic REQ_TAKE = 1'b0;
  localparam logic REQ_GIVE = 1'b1;

  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES  = 2 * SlotCount + 8;
  localparam int unsigned PHASE_COUNT    = 7;
  localparam int unsigned PHASE_ITEMS    = 215;
  localparam int unsigned NUM_DIRECTED   = 23;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] handle;
    logic [CapW-1:0]    capacity;
  } pool_result_t;

  typedef struct packed {
    logic               req;
    logic [CapW-1:0]    size;
    logic [HandleW-1:0] handle;
    logic               typed;
    pool_result_t       res;
  } stim_row_t;

  localparam pool_result_t NO_RES = '{ST_MISS, 16'd0, 32'd0};

  // Directed rows run under the reset window of 64..65536
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{REQ_TAKE, 32'd0,          16'hFFFF, 1'b1, '{ST_MISS,     16'd0,     32'd0}},
    '{REQ_GIVE, 32'd63,         16'hFFFF, 1'b1, '{ST_WINDOW,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd65537,      16'h1234, 1'b1, '{ST_WINDOW,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'hFFFF_FFFF,  16'h0000, 1'b1, '{ST_WINDOW,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd0,          16'h5555, 1'b1, '{ST_WINDOW,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd64,         16'h0001, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd65536,      16'hFFFF, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd500,        16'h0002, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd500,        16'h0003, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd64,         16'h0004, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd1000,       16'hAAAA, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd2000,       16'h5555, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd300,        16'h8000, 1'b1, '{ST_STORED,   16'd0,     32'd0}},
    '{REQ_GIVE, 32'd64,         16'h00FF, 1'b1, '{ST_SMALL,    16'd0,     32'd0}},
    '{REQ_GIVE, 32'd65,         16'h7FFF, 1'b1, '{ST_REPLACED, 16'h0001,  32'd64}},
    '{REQ_GIVE, 32'd65,         16'h0F0F, 1'b1, '{ST_REPLACED, 16'h0004,  32'd64}},
    '{REQ_GIVE, 32'd65,         16'h1111, 1'b1, '{ST_SMALL,    16'd0,     32'd0}},
    '{REQ_TAKE, 32'hFFFF_FFFF,  16'h0000, 1'b1, '{ST_MISS,     16'd0,     32'd0}},
    '{REQ_TAKE, 32'd0,          16'h0000, 1'b0, NO_RES},
    '{REQ_TAKE, 32'd65536,      16'hFFFF, 1'b0, NO_RES},
    '{REQ_TAKE, 32'd501,        16'h0000, 1'b0, NO_RES},
    '{REQ_TAKE, 32'd65,         16'h0000, 1'b0, NO_RES},
    '{REQ_TAKE, 32'd0,          16'h0000, 1'b0, NO_RES}
  };

  // DUT signals, all inputs known from time zero
  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx       = CfgMinRetain;
  logic [CapW-1:0]    cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               req_type      = REQ_TAKE;
  logic [CapW-1:0]    size_value    = '0;
  logic [HandleW-1:0] buffer_handle = '0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [2:0]         status;
  logic [HandleW-1:0] out_handle;
  logic [CapW-1:0]    out_capacity;

  // Predictor state
  logic [CapW-1:0]    pool_cap    [SlotCount];
  logic [HandleW-1:0] pool_handle [SlotCount];
  int unsigned        pool_live;
  logic [CapW-1:0]    keep_min;
  logic [CapW-1:0]    keep_max;

  pool_result_t       pending_results [$];
  int unsigned        fail_count;
  int unsigned        quiet_cycles;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  logic [CapW-1:0]    palette [4];

  bounded_buffer_spare_pool u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .size_value_i    (size_value),
    .buffer_handle_i (buffer_handle),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .out_handle_o    (out_handle),
    .out_capacity_o  (out_capacity)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the result of one request and advance the pool copy
  function automatic pool_result_t predict_request(input logic req,
                                                   input logic [CapW-1:0] size,
                                                   input logic [HandleW-1:0] handle);
    pool_result_t res;
    logic         found;
    int unsigned  best;
    res   = '{ST_MISS, 16'd0, 32'd0};
    found = 1'b0;
    best  = 0;
    if (req == REQ_TAKE) begin
      // scan newest first; fill the hole with the last live slot
      for (int i = int'(pool_live) - 1; i >= 0; i--) begin
        if (!found && pool_cap[i] >= size) begin
          found = 1'b1;
          res   = '{ST_HIT, pool_handle[i], pool_cap[i]};
          pool_cap[i]    = pool_cap[pool_live-1];
          pool_handle[i] = pool_handle[pool_live-1];
          pool_live--;
        end
      end
    end else if (size < keep_min || size > keep_max) begin
      res = '{ST_WINDOW, 16'd0, 32'd0};
    end else if (pool_live < SlotCount) begin
      pool_cap[pool_live]    = size;
      pool_handle[pool_live] = handle;
      pool_live++;
      res = '{ST_STORED, 16'd0, 32'd0};
    end else begin
      // full: smallest spare, first index on ties, must be strictly beaten
      for (int i = 1; i < SlotCount; i++) begin
        if (pool_cap[i] < pool_cap[best]) best = unsigned'(i);
      end
      if (size <= pool_cap[best]) begin
        res = '{ST_SMALL, 16'd0, 32'd0};
      end else begin
        res = '{ST_REPLACED, pool_handle[best], pool_cap[best]};
        pool_cap[best]    = size;
        pool_handle[best] = handle;
      end
    end
    return res;
  endfunction

  // Offer one transaction, hold it until accepted, then queue its result
  task automatic send_request(input logic req, input logic [CapW-1:0] size,
                              input logic [HandleW-1:0] handle, input logic typed,
                              input pool_result_t typed_res);
    pool_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    size_value    <= size;
    buffer_handle <= handle;
    do @(posedge clk); while (in_stall);
    predicted = predict_request(req, size, handle);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Drop the request, then wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write both window registers on back-to-back cycles
  task automatic set_window(input logic [CapW-1:0] lo, input logic [CapW-1:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgMinRetain;
    cfg_data <= lo;
    @(negedge clk);
    cfg_idx  <= CfgMaxRetain;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we   <= 1'b0;
    keep_min = lo;
    keep_max = hi;
  endtask

  function automatic logic [CapW-1:0] pick_give_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return $urandom();
    if (r < 12 && keep_min > 0) return keep_min - 1;
    if (r < 16 && keep_max < 32'hFFFF_FFFF) return keep_max + 1;
    if (r < 20) return keep_min;
    if (r < 24) return keep_max;
    if (r < 55) return palette[$urandom_range(3)];
    if (keep_min <= keep_max) return $urandom_range(keep_max, keep_min);
    return $urandom();
  endfunction

  function automatic logic [CapW-1:0] pick_take_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 13) return 32'hFFFF_FFFF;
    if (r < 50 && pool_live > 0)
      return pool_cap[$urandom_range(pool_live - 1)] + $urandom_range(1);
    if (r < 70) return palette[$urandom_range(3)];
    if (r < 85 && keep_min <= keep_max) return $urandom_range(keep_max, keep_min);
    return $urandom() >> $urandom_range(31);
  endfunction

  // Receiver side stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d handle %h capacity %h",
                   status, out_handle, out_capacity);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || out_handle !== want.handle ||
            out_capacity !== want.capacity) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d handle %h capacity %h, got %0d %h %h",
                     want.status, want.handle, want.capacity,
                     status, out_handle, out_capacity);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [CapW-1:0] lo;
    logic [CapW-1:0] hi;
    logic [CapW-1:0] phase_min [PHASE_COUNT];
    logic [CapW-1:0] phase_max [PHASE_COUNT];
    int unsigned     item_no;
    int unsigned     take_pct;
    logic            req;

    fail_count    = 0;
    quiet_cycles  = 0;
    pool_live     = 0;
    keep_min      = MinRetainRst;
    keep_max      = MaxRetainRst;
    send_idle_pct = 38;
    recv_idle_pct = 74;
    item_no       = 0;
    take_pct      = 50;

    // Hold reset, then release it on a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at the reset window
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].size, directed_rows[i].handle,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    // Windows: full range, empty, zero only, top only, random, narrow, reset
    phase_min = '{32'd0, 32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd64};
    phase_max = '{32'hFFFF_FFFF, 32'd999, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd200, 32'd65536};
    phase_min[4] = $urandom_range(5000);
    phase_max[4] = phase_min[4] + $urandom_range(100000);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      lo = phase_min[p];
      hi = phase_max[p];
      set_window(lo, hi);
      // a few recurring capacities to make ties and hits
      palette[0] = lo;
      for (int j = 1; j < 4; j++)
        palette[j] = (lo <= hi) ? $urandom_range(hi, lo) : $urandom();

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (item_no == 500) begin
          send_idle_pct = 74;
          recv_idle_pct = 38;
        end else if (item_no == 1000) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (k % 40 == 0) take_pct = 20 + 25 * $urandom_range(2);
        req = ($urandom_range(99) < take_pct) ? REQ_TAKE : REQ_GIVE;
        send_request(req, (req == REQ_TAKE) ? pick_take_size() : pick_give_size(),
                     HandleW'($urandom_range(16'hFFFF)), 1'b0, NO_RES);
        item_no++;
      end
    end

    // Let the last results out, then settle
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
